### sv/cle_pkg.sv
// ----------------------------------------------------------------------------
// Console line editor package
// Shared types, key codes and defaults for the console line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

    localparam int CLE_LINE_CAPACITY = 2048;
    localparam logic [11:0] CLE_LIMIT_RESET = 12'd2048;

    localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_RETURN    = 8'h0D;
    localparam logic [7:0] KEY_SPACE     = 8'h20;

    typedef enum logic [0:0] {
        OP_KEY  = 1'b0,
        OP_READ = 1'b1
    } cle_op_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_ECHO = 2'd1,
        ACT_HOME = 2'd2
    } cle_action_t;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_WRITE = 2'd1,
        MEM_READ  = 2'd2
    } cle_mem_op_t;

    typedef struct packed {
        cle_op_t     operation;
        logic [7:0]  key_byte;
        logic        has_data;
        logic        is_press;
        logic [10:0] read_index;
    } cle_in_t;

    typedef struct packed {
        cle_action_t action;
        logic [7:0]  echo_byte;
        logic        line_done;
        logic [11:0] line_length;
        logic [7:0]  read_byte;
    } cle_out_t;

    // Work handed from the front to the back; the store address travels beside it.
    typedef struct packed {
        cle_mem_op_t mem_op;
        logic [7:0]  wdata;
        cle_action_t action;
        logic [7:0]  echo_byte;
        logic        line_done;
        logic [11:0] line_length;
    } cle_cmd_t;

endpackage

`default_nettype wire

### sv/cle_front.sv
// ----------------------------------------------------------------------------
// Console line editor front end
// Accepts requests, keeps the edit position and line state, and issues one
// store command with its result fields for every request.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_front
    import cle_pkg::*;
#(
    parameter int LINE_CAPACITY = CLE_LINE_CAPACITY,
    localparam int AW = $clog2(LINE_CAPACITY)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_stall,
    input  wire cle_in_t       in_data,
    input  wire logic          cfg_we,
    input  wire logic [11:0]   cfg_wdata,
    output      logic          cmd_valid,
    input  wire logic          cmd_full,
    output      cle_cmd_t      cmd,
    output      logic [AW-1:0] cmd_addr
);

    localparam int PW = AW + 1;
    localparam int CW = (PW > 12) ? PW : 12;
    localparam logic [CW-1:0] CAP_C = CW'(LINE_CAPACITY);

    logic [11:0]   line_limit_reg;
    logic [PW-1:0] edit_pos_reg;
    logic [PW-1:0] edit_pos_next;
    logic [PW-1:0] high_water_reg;
    logic [PW-1:0] high_water_next;
    logic          finished_reg;
    logic          finished_next;

    logic          accept;
    logic          counted;
    logic [PW-1:0] pos0;
    logic [PW-1:0] hw0;
    logic [PW-1:0] pos_inc;
    logic [PW-1:0] pos_dec;
    logic [PW-1:0] hw_inc;
    logic [CW-1:0] lim_ext;
    logic [CW-1:0] lim_eff;
    logic [CW-1:0] hw0_ext;
    logic [CW-1:0] pos0_ext;
    logic [CW-1:0] hw_inc_ext;
    logic [CW-1:0] ridx_ext;
    logic          room;

    assign in_stall  = cmd_full;
    assign accept    = in_valid && !cmd_full;
    assign cmd_valid = accept;
    assign counted   = (in_data.operation == OP_KEY) && in_data.has_data && in_data.is_press;

    // A counted key after a completed line starts over from an empty line.
    assign pos0     = finished_reg ? '0 : edit_pos_reg;
    assign hw0      = finished_reg ? '0 : high_water_reg;
    assign pos_inc  = pos0 + PW'(1);
    assign pos_dec  = pos0 - PW'(1);
    assign hw_inc   = (pos_inc > hw0) ? pos_inc : hw0;

    assign lim_ext    = CW'(line_limit_reg);
    assign lim_eff    = (lim_ext > CAP_C) ? CAP_C : lim_ext;
    assign hw0_ext    = CW'(hw0);
    assign pos0_ext   = CW'(pos0);
    assign hw_inc_ext = CW'(hw_inc);
    assign ridx_ext   = CW'(in_data.read_index);
    assign room       = pos0_ext < CAP_C;

    always_comb
    begin
        edit_pos_next   = edit_pos_reg;
        high_water_next = high_water_reg;
        finished_next   = finished_reg;
        cmd             = '0;
        cmd.mem_op      = MEM_NONE;
        cmd.action      = ACT_NONE;
        cmd_addr        = pos0[AW-1:0];

        if (in_data.operation == OP_READ) begin
            cmd_addr = ridx_ext[AW-1:0];
            if (ridx_ext < CAP_C) begin
                cmd.mem_op = MEM_READ;
            end
        end else if (counted) begin
            edit_pos_next   = pos0;
            high_water_next = hw0;
            finished_next   = 1'b0;
            if ((in_data.key_byte == KEY_NEWLINE) || (hw0_ext >= lim_eff)) begin
                cmd.line_done   = 1'b1;
                cmd.line_length = hw0_ext[11:0];
                finished_next   = 1'b1;
                if ((in_data.key_byte == KEY_NEWLINE) && (hw0_ext < lim_eff) && room) begin
                    cmd.mem_op      = MEM_WRITE;
                    cmd.wdata       = KEY_NEWLINE;
                    cmd.action      = ACT_ECHO;
                    cmd.echo_byte   = KEY_NEWLINE;
                    cmd.line_length = hw_inc_ext[11:0];
                    edit_pos_next   = pos_inc;
                    high_water_next = hw_inc;
                end
            end else if (in_data.key_byte == KEY_BACKSPACE) begin
                if (pos0 != '0) begin
                    cmd.mem_op    = MEM_WRITE;
                    cmd.wdata     = KEY_SPACE;
                    cmd.action    = ACT_ECHO;
                    cmd.echo_byte = KEY_BACKSPACE;
                    cmd_addr      = pos_dec[AW-1:0];
                    edit_pos_next = pos_dec;
                end
            end else if (in_data.key_byte == KEY_RETURN) begin
                cmd.action    = ACT_HOME;
                edit_pos_next = '0;
            end else if (room) begin
                cmd.mem_op      = MEM_WRITE;
                cmd.wdata       = in_data.key_byte;
                cmd.action      = ACT_ECHO;
                cmd.echo_byte   = in_data.key_byte;
                edit_pos_next   = pos_inc;
                high_water_next = hw_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_limit_reg <= CLE_LIMIT_RESET;
            edit_pos_reg   <= '0;
            high_water_reg <= '0;
            finished_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                line_limit_reg <= cfg_wdata;
            end
            if (accept) begin
                edit_pos_reg   <= edit_pos_next;
                high_water_reg <= high_water_next;
                finished_reg   <= finished_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(edit_pos_reg) <= CAP_C)
        else $error("edit position beyond line capacity");

    a_hw_covers_pos: assert property (@(posedge clk) disable iff (!rst_n)
        accept && counted && (cmd.action == ACT_ECHO) && (cmd.wdata != KEY_SPACE)
        |=> (high_water_reg >= edit_pos_reg))
        else $error("high-water length fell below the edit position");
`endif

endmodule

`default_nettype wire

### sv/cle_queue.sv
// ----------------------------------------------------------------------------
// Console line editor command queue
// Two-entry queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_queue
    import cle_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output      logic              full,
    input  wire logic              pop,
    output      logic              not_empty,
    output      logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

### sv/cle_back.sv
// ----------------------------------------------------------------------------
// Console line editor back end
// Performs the store write or read of each command and holds the result in
// an output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_back
    import cle_pkg::*;
#(
    parameter int LINE_CAPACITY = CLE_LINE_CAPACITY,
    localparam int AW = $clog2(LINE_CAPACITY)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_ready,
    input  wire cle_cmd_t      cmd,
    input  wire logic [AW-1:0] cmd_addr,
    output      logic          cmd_pop,
    output      logic          out_valid,
    input  wire logic          out_stall,
    output      cle_out_t      out_data
);

    logic [7:0]  line_store [LINE_CAPACITY];
    logic [7:0]  rdata_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        is_read_reg;
    cle_cmd_t    res_reg;

    assign cmd_pop = cmd_ready && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_pop) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The store is touched only when a command is popped, so the read data
    // holds while the result waits.
    always_ff @(posedge clk)
    begin
        if (cmd_pop) begin
            res_reg     <= cmd;
            is_read_reg <= (cmd.mem_op == MEM_READ);
            if (cmd.mem_op == MEM_WRITE) begin
                line_store[cmd_addr] <= cmd.wdata;
            end
            if (cmd.mem_op == MEM_READ) begin
                rdata_reg <= line_store[cmd_addr];
            end
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_data.action       = res_reg.action;
    assign out_data.echo_byte    = res_reg.echo_byte;
    assign out_data.line_done    = res_reg.line_done;
    assign out_data.line_length  = res_reg.line_length;
    assign out_data.read_byte    = is_read_reg ? rdata_reg : 8'h00;

`ifndef NO_ASSERTIONS
    a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> out_valid_reg)
        else $error("popped command did not reach the output register");

    a_done_not_home: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.line_done |-> (res_reg.action != ACT_HOME))
        else $error("completed line reported with a cursor-home action");
`endif

endmodule

`default_nettype wire

### sv/console_line_editor.sv
// ----------------------------------------------------------------------------
// Console line editor
// Edits one console line from keyboard requests and returns stored bytes.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid/in_stall    cle_in_t
//   out       output     out_valid/out_stall  cle_out_t
//   cfg       input      cfg_we               cfg_wdata (line limit)
//
// One request per cycle is sustained while the output is not stalled. A
// request is written into the queue when accepted and then moves into the
// output register, where its result is held until the receiver takes it.
// The line store is a single-port memory touched at most once per request.
// Reset clears the edit position, high-water length and line-complete flag;
// the line store is not cleared.
// in_stall rises only when the two-entry queue is full behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor
    import cle_pkg::*;
#(
    parameter int LINE_CAPACITY = CLE_LINE_CAPACITY
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire cle_in_t     in_data,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      cle_out_t    out_data,
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata
);

    localparam int AW     = $clog2(LINE_CAPACITY);
    localparam int CMD_W  = $bits(cle_cmd_t);
    localparam int DATA_W = CMD_W + AW;

    logic              push;
    logic              q_full;
    logic              q_not_empty;
    logic              pop;
    cle_cmd_t          front_cmd;
    logic [AW-1:0]     front_addr;
    logic [DATA_W-1:0] q_out;
    cle_cmd_t          back_cmd;
    logic [AW-1:0]     back_addr;

    cle_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (push),
        .cmd_full  (q_full),
        .cmd       (front_cmd),
        .cmd_addr  (front_addr)
    );

    cle_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_addr, front_cmd}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign back_cmd  = cle_cmd_t'(q_out[CMD_W-1:0]);
    assign back_addr = q_out[DATA_W-1:CMD_W];

    cle_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ready (q_not_empty),
        .cmd       (back_cmd),
        .cmd_addr  (back_addr),
        .cmd_pop   (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
